### hdl/sls_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted list set engine.
// No dependencies.
package sls_pkg;

  localparam int DEF_CAPACITY   = 2048;
  localparam int DEF_VALUE_BITS = 16;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 12;

  // operation codes; the unused code behaves as a member query
  localparam logic [FUNC_W-1:0] OP_MEMBER = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_REDUCE,
    S_APPLY
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic capture;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

### hdl/sls_channels.sv
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready handshake).
// Depends on sls_pkg.
interface sls_req_if import sls_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sls_rsp_if import sls_pkg::*;;
  logic               valid;
  logic               ready;
  logic               found;
  status_t            status;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output found, output status, output count, input ready);
  modport sink   (input valid, input found, input status, input count, output ready);
endinterface

### hdl/sls_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds one element, compares it with
// the key and shifts toward its neighbors. Depends on sls_pkg.
module sls_cell import sls_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] key,
  input  logic                  in_use,
  input  logic [VALUE_BITS-1:0] left_data,
  input  logic                  left_lt,
  input  logic [VALUE_BITS-1:0] right_data,
  output logic [VALUE_BITS-1:0] data,
  output logic                  lt,
  output logic                  eq
);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lt <= in_use && (data < key);
      eq <= in_use && (data == key);
    end else if (cmd.ins) begin
      // cells past the insert point take the left neighbor, the insert point takes the key
      if (!left_lt) begin
        data <= left_data;
      end else if (!lt) begin
        data <= key;
      end
    end else if (cmd.del) begin
      if (!lt) begin
        data <= right_data;
      end
    end
  end

endmodule

### hdl/sls_hit_tree.sv
`timescale 1ns / 1ps
// Registered OR tree over the cell match flags; one level per cycle.
// No package dependencies.
module sls_hit_tree #(
  parameter int LEAVES = 2048
) (
  input  logic              clk,
  input  logic [LEAVES-1:0] leaves,
  output logic              hit
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int P      = 1 << LEVELS;

  logic [P-1:0] pad;
  logic [P-1:1] node;

  for (genvar i = 0; i < P; i++) begin : g_pad
    if (i < LEAVES) begin : g_real
      assign pad[i] = leaves[i];
    end else begin : g_zero
      assign pad[i] = 1'b0;
    end
  end

  // heap layout: node j has children 2j and 2j+1, leaves sit at P..2P-1
  for (genvar j = 1; j < P; j++) begin : g_node
    if (2 * j >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        node[j] <= pad[2*j-P] | pad[2*j+1-P];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[j] <= node[2*j] | node[2*j+1];
      end
    end
  end

  assign hit = node[1];

endmodule

### hdl/sorted_list_set_engine_top.sv
`timescale 1ns / 1ps
// Sorted list set engine: a row of compare-and-shift cells keeping an
// ascending list of keys. Depends on sls_pkg, sls_channels, sls_cell, sls_hit_tree.
//
// Requests arrive on req (func, value); each yields one response on rsp
// (found, status, count). func: member query, insert, delete; the unused
// code acts as a member query. Insert places the key ahead of the first
// element >= key (duplicates kept); delete removes the first equal element.
//
// One request is worked at a time; the engine takes no new request until it
// is back in idle. From acceptance a request passes the compare state in all
// cells, then the reduce state that walks the registered match tree level by
// level, then the apply state in which every cell shifts at once and the
// response register loads. req.ready is high whenever no request is in
// progress, also while a response waits in the output register; a stalled
// response holds the next request in its apply state.
// Synchronous reset empties the list (count 0) and drops any pending
// response; cell contents are left as they are and never read past count.
module sorted_list_set_engine_top import sls_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic  clk,
  input  logic  rst,
  sls_req_if.sink   req,
  sls_rsp_if.source rsp
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = $clog2(CAPACITY);
  localparam int LVL_W  = $clog2(LEVELS + 1);

  state_t               state, state_next;
  logic [LVL_W-1:0]     lvl_cnt, lvl_cnt_next;
  logic [CW-1:0]        count, count_next;
  logic [FUNC_W-1:0]    op;
  logic [VALUE_BITS-1:0] key, key_in;
  logic                 rsp_valid;
  logic                 rsp_found;
  status_t              rsp_status, status_next;
  logic [COUNT_W-1:0]   rsp_count, count_out;
  logic                 commit;
  logic                 hit;
  logic                 full;
  cell_cmd_t            cmd;

  logic [VALUE_BITS-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_lt;
  logic [CAPACITY-1:0]   cell_eq;

  if (VALUE_BITS >= VALUE_W) begin : g_key_wide
    assign key_in = VALUE_BITS'(req.value);
  end else begin : g_key_narrow
    assign key_in = req.value[VALUE_BITS-1:0];
  end

  if (CW >= COUNT_W) begin : g_cnt_cut
    assign count_out = count_next[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign count_out = COUNT_W'(count_next);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_data, right_data;
    logic                  left_lt;
    logic                  in_use;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_lt   = 1'b1;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    assign in_use = (CW'(i) < count);

    sls_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key),
      .in_use    (in_use),
      .left_data (left_data),
      .left_lt   (left_lt),
      .right_data(right_data),
      .data      (cell_data[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  sls_hit_tree #(
    .LEAVES(CAPACITY)
  ) u_hit_tree (
    .clk   (clk),
    .leaves(cell_eq),
    .hit   (hit)
  );

  assign full      = (count == CW'(CAPACITY));
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    lvl_cnt_next = lvl_cnt;
    count_next   = count;
    status_next  = STAT_DONE;
    commit       = 1'b0;
    cmd          = '0;

    if (op == OP_INSERT) begin
      if (full) begin
        status_next = STAT_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else if (op == OP_DELETE) begin
      if (!hit) begin
        status_next = STAT_MISSING;
      end else begin
        count_next = count - CW'(1);
      end
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.capture  = 1'b1;
        lvl_cnt_next = LVL_W'(LEVELS - 1);
        state_next   = S_REDUCE;
      end
      S_REDUCE: begin
        if (lvl_cnt == '0) begin
          state_next = S_APPLY;
        end else begin
          lvl_cnt_next = lvl_cnt - LVL_W'(1);
        end
      end
      S_APPLY: begin
        // wait here while the previous response is still unclaimed
        if (!rsp_valid || rsp.ready) begin
          commit     = 1'b1;
          cmd.ins    = (op == OP_INSERT) && !full;
          cmd.del    = (op == OP_DELETE) && hit;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl_cnt   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      lvl_cnt <= lvl_cnt_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= req.func;
      key <= key_in;
    end
    if (commit) begin
      rsp_found  <= hit;
      rsp_status <= status_next;
      rsp_count  <= count_out;
    end
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.found  = rsp_found;
  assign rsp.status = rsp_status;
  assign rsp.count  = rsp_count;

endmodule

### sim/tb_sorted_list_set_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted list set engine: directed, random and
// backpressure requests, checked against an in-bench sorted-list predictor.
// Depends on sls_pkg, sls_channels and sorted_list_set_engine_top.
module tb_sorted_list_set_engine_top import sls_pkg::*;;

  localparam int LIST_CAP    = DEF_CAPACITY;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 48;
  localparam int HOLD_LEN    = 400;
  localparam logic [FUNC_W-1:0] OP_SPARE = 2'd3;  // unused code, behaves as member

  typedef struct {
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  logic clk = 1'b0;
  logic rst;

  sls_req_if req_ch ();
  sls_rsp_if rsp_ch ();

  sorted_list_set_engine_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  logic [VALUE_W-1:0] stored_keys[$];       // predicted list contents, ascending
  set_result_t        pending_results[$];   // expected responses, oldest first
  int mismatch_count = 0;
  int snd_idle_pct   = 0;
  int rsp_idle_pct   = 0;
  int cyc            = 0;
  int rsp_hold_until = 0;
  int stall_cycles   = 0;

  always @(posedge clk) cyc <= cyc + 1;

  // response sink: random stalls, plus a forced hold-off window
  always @(posedge clk) begin
    if (cyc < rsp_hold_until) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  function automatic set_result_t predict_set_op(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v);
    set_result_t r;
    int pos;
    pos = 0;
    while (pos < stored_keys.size() && stored_keys[pos] < v) pos++;
    r.found  = (pos < stored_keys.size()) && (stored_keys[pos] == v);
    r.status = STAT_DONE;
    if (f == OP_INSERT) begin
      if (stored_keys.size() >= LIST_CAP) r.status = STAT_FULL;
      else stored_keys.insert(pos, v);
    end else if (f == OP_DELETE) begin
      if (!r.found) r.status = STAT_MISSING;
      else stored_keys.delete(pos);
    end
    r.count = COUNT_W'(stored_keys.size());
    return r;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    mismatch_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  // fields are stable at the falling edge; a response seen here is taken at the next rise
  always @(negedge clk) begin : rsp_check
    set_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("response with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (want.found !== rsp_ch.found) note_mismatch("found", want.found, rsp_ch.found);
        if (want.status !== rsp_ch.status) note_mismatch("status", want.status, rsp_ch.status);
        if (want.count !== rsp_ch.count) note_mismatch("count", want.count, rsp_ch.count);
      end
    end
  end

  always @(negedge clk) begin : watchdog
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Leaves valid high on return so the next request can follow back to back.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.value <= v;
    do @(negedge clk); while (req_ch.ready !== 1'b1);
    @(posedge clk);
    pending_results.insert(pending_results.size(), predict_set_op(f, v));
  endtask

  task automatic send_random_op();
    logic [FUNC_W-1:0]  f;
    logic [VALUE_W-1:0] v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 42) f = OP_INSERT;
    else if (pick < 77) f = OP_DELETE;
    else if (pick < 95) f = OP_MEMBER;
    else f = OP_SPARE;
    pick = $urandom_range(99);
    if (pick < 40 && stored_keys.size() > 0) begin
      v = stored_keys[$urandom_range(stored_keys.size() - 1)];
    end else if (pick < 70) begin
      v = VALUE_W'($urandom_range(31));    // dense range: duplicates and hits
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: v = '0;
        1: v = '1;
        2: v = {1'b1, {(VALUE_W-1){1'b0}}};
        default: v = {1'b0, {(VALUE_W-1){1'b1}}};
      endcase
    end else begin
      v = VALUE_W'($urandom);
    end
    send_request(f, v);
  endtask

  task automatic test_directed();
    snd_idle_pct = 17;
    rsp_idle_pct = 56;
    send_request(OP_MEMBER, 16'h0000);   // empty list
    send_request(OP_DELETE, 16'h0005);   // delete from empty list
    send_request(OP_INSERT, 16'hFFFF);
    send_request(OP_INSERT, 16'h0000);
    send_request(OP_INSERT, 16'h8000);
    send_request(OP_INSERT, 16'h8000);   // duplicate kept
    send_request(OP_MEMBER, 16'h8000);
    send_request(OP_SPARE,  16'hFFFF);
    send_request(OP_SPARE,  16'h1234);
    send_request(OP_DELETE, 16'h8000);
    send_request(OP_MEMBER, 16'h8000);   // second copy still there
    send_request(OP_DELETE, 16'h8000);
    send_request(OP_DELETE, 16'h8000);   // now missing
    send_request(OP_INSERT, 16'h7FFF);
    send_request(OP_INSERT, 16'h0001);
    send_request(OP_INSERT, 16'hFFFE);
    send_request(OP_DELETE, 16'h0000);   // head
    send_request(OP_DELETE, 16'hFFFF);   // tail
    send_request(OP_MEMBER, 16'hAAAA);
    send_request(OP_INSERT, 16'h5555);
    send_request(OP_INSERT, 16'hAAAA);
    send_request(OP_MEMBER, 16'h5555);
  endtask

  task automatic test_random_traffic(input int n, input int snd_pct, input int rsp_pct);
    int k;
    snd_idle_pct = snd_pct;
    rsp_idle_pct = rsp_pct;
    for (k = 0; k < n; k++) send_random_op();
  endtask

  // sink holds off while requests keep coming, so the engine fills and stalls req
  task automatic test_rsp_backpressure();
    int k;
    req_ch.valid <= 1'b0;
    @(negedge clk);
    rsp_hold_until = cyc + HOLD_LEN;
    @(posedge clk);
    snd_idle_pct = 0;
    rsp_idle_pct = 0;
    for (k = 0; k < 20; k++) send_random_op();
  endtask

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func  <= OP_MEMBER;
    req_ch.value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(230, 17, 56);
    test_random_traffic(230, 56, 17);
    test_rsp_backpressure();
    test_random_traffic(200, 0, 0);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sorted_list_set_engine_top.f
hdl/sls_pkg.sv
hdl/sls_channels.sv
hdl/sls_cell.sv
hdl/sls_hit_tree.sv
hdl/sorted_list_set_engine_top.sv
sim/tb_sorted_list_set_engine_top.sv
